// ===== rtl/kot_pkg.sv =====
// ----------------------------------------------------------------------------
// kot_pkg
// Shared types and codes for the keyed object table: command and status
// codes, request and response words, the stored entry and sequencer states.
// ----------------------------------------------------------------------------
package kot_pkg;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_SET    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_RSVD   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RSVD      = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [63:0]        hwnd;
		logic [31:0]        object_type;
		logic signed [31:0] child_id;
		logic [63:0]        new_callback;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] found_callback;
	} rsp_t;

	typedef struct packed {
		logic [63:0]        hwnd;
		logic [31:0]        object_type;
		logic signed [31:0] child_id;
		logic [63:0]        callback;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESOLVE
	} state_t;

endpackage

// ===== rtl/kot_store.sv =====
// ----------------------------------------------------------------------------
// kot_store
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kot_store import kot_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/keyed_object_table_core.sv =====
// ----------------------------------------------------------------------------
// keyed_object_table_core
// Keyed table of callback entries with lookup, set/insert and remove, served
// by a sequential scan over the entry store with one key comparator.
// ----------------------------------------------------------------------------
// One request is served at a time: a new request is accepted only in the idle state, after the
// previous request has been resolved; the scan reads one entry per cycle through the single
// store read port.
// Reset clears all valid marks at once; key and callback storage is not reset.
// ----------------------------------------------------------------------------
module keyed_object_table_core import kot_pkg::*; #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	state_t state_q, state_d;

	logic [TABLE_ENTRIES-1:0] valid_q;
	req_t                     req_q;
	logic [IW-1:0]            idx_q;
	logic                     issue_q;
	logic [IW-1:0]            cmp_idx_s1;
	logic                     cmp_act_s1;
	logic                     cmp_vld_s1;
	logic                     hit_q;
	logic [IW-1:0]            hit_idx_q;
	logic [63:0]              hit_cb_q;
	logic                     free_q;
	logic [IW-1:0]            free_idx_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	logic   accept;
	logic   scan_end;
	logic   resolve_go;
	logic   key_eq;
	entry_t rd_entry;
	logic   wr_en;
	logic [IW-1:0] wr_addr;
	entry_t wr_entry;

	assign accept   = req_valid && req_ready;
	assign scan_end = cmp_act_s1 && (cmp_idx_s1 == LAST);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_end) state_d = S_RESOLVE;
			end
			S_RESOLVE: begin
				if (!rsp_valid_q || rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_ready  = 1'b0;
		resolve_go = 1'b0;
		case (state_q)
			S_IDLE:    req_ready  = 1'b1;
			S_SCAN:    ;
			S_RESOLVE: resolve_go = !rsp_valid_q || rsp_ready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	kot_store #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (IW)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	assign key_eq = (rd_entry.hwnd == req_q.hwnd) &&
		(rd_entry.object_type == req_q.object_type) &&
		(rd_entry.child_id == req_q.child_id);

	// Scan control: issue one read per cycle, compare in the cycle after each read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= 1'b0;
			idx_q      <= '0;
			cmp_act_s1 <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
		end else if (accept) begin
			issue_q    <= 1'b1;
			idx_q      <= '0;
			cmp_act_s1 <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
		end else begin
			cmp_act_s1 <= issue_q;
			cmp_vld_s1 <= issue_q && valid_q[idx_q];
			if (issue_q) begin
				if (idx_q == LAST) begin
					issue_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
				if (!valid_q[idx_q] && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (cmp_vld_s1 && key_eq && !hit_q) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Payload captures
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		cmp_idx_s1 <= idx_q;
		if (issue_q && !valid_q[idx_q] && !free_q) begin
			free_idx_q <= idx_q;
		end
		if (cmp_vld_s1 && key_eq && !hit_q) begin
			hit_idx_q <= cmp_idx_s1;
			hit_cb_q  <= rd_entry.callback;
		end
	end

	// Resolve: a hit on set rewrites its own slot, so one write path serves both cases
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_q ? hit_idx_q : free_idx_q;
		wr_entry.hwnd        = req_q.hwnd;
		wr_entry.object_type = req_q.object_type;
		wr_entry.child_id    = req_q.child_id;
		wr_entry.callback    = req_q.new_callback;
		if (resolve_go && (req_q.command == CMD_SET) && (hit_q || free_q)) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (resolve_go) begin
			if (req_q.command == CMD_SET && !hit_q && free_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end else if (req_q.command == CMD_REMOVE && hit_q) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (resolve_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resolve_go) begin
			rsp_q.found_callback <= '0;
			case (req_q.command)
				CMD_LOOKUP: begin
					rsp_q.status <= hit_q ? ST_OK : ST_NOT_FOUND;
					if (hit_q) rsp_q.found_callback <= hit_cb_q;
				end
				CMD_SET: begin
					rsp_q.status <= (hit_q || free_q) ? ST_OK : ST_FULL;
				end
				CMD_REMOVE: begin
					rsp_q.status <= hit_q ? ST_OK : ST_NOT_FOUND;
				end
				default: begin
					rsp_q.status <= ST_NOT_FOUND;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
